>>> hw/rtl/asd_pkg.sv
`default_nettype none

package asd_pkg;

   // register and field widths
   localparam int DIM_W     = 13;
   localparam int COL_W     = 12;
   localparam int VAL_W     = 8;
   localparam int SAMPLE_W  = 8;
   localparam int PIX_W     = 10;
   localparam int WEIGHT_W  = 2;
   localparam int SUM_W     = 26;
   localparam int CNT_W     = 18;
   localparam int RATIO_W   = 24;
   localparam int FRAC_W    = 16;
   localparam int ACC_W     = 38;
   localparam int E_W       = ACC_W - FRAC_W;

   localparam logic [RATIO_W-1:0] ONE_Q16  = 24'h010000;
   localparam logic [RATIO_W-1:0] HALF_Q16 = 24'h008000;

   // results caused by one item at most
   localparam int RESULT_BUDGET = 4;
   localparam int N_W           = 3;

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_WIDTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_HEIGHT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_RATIO = 3'd5;

   // divider: two quotient bits per cycle
   localparam int DIV_BITS_PER_CYCLE = 2;
   localparam int DIV_STEPS          = SUM_W / DIV_BITS_PER_CYCLE;
   localparam int DIV_CNT_W          = 4;

   typedef struct packed {
      logic             done;
      logic [VAL_W-1:0] quotient;
   } div_status_type;

endpackage

`default_nettype wire

>>> hw/rtl/asd_divider.sv
`default_nettype none

module asd_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [asd_pkg::SUM_W-1:0]  num,
   input  logic [asd_pkg::CNT_W-1:0]  den,
   output asd_pkg::div_status_type    status
);
   import asd_pkg::*;

   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [SUM_W-1:0]     quo_ff, quo_in;
   logic [CNT_W-1:0]     den_ff;
   logic [DIV_CNT_W-1:0] step_ff;
   logic                 busy_ff;
   logic                 done_ff;

   // restoring division, numerator bits shift out of the quotient register
   always_comb begin
      logic [CNT_W:0] trial;
      logic           qbit;
      rem_in = rem_ff;
      quo_in = quo_ff;
      for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
         trial = {rem_in, quo_in[SUM_W-1]};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = CNT_W'(trial - {1'b0, den_ff});
            qbit   = 1'b1;
         end else begin
            rem_in = trial[CNT_W-1:0];
            qbit   = 1'b0;
         end
         quo_in = {quo_in[SUM_W-2:0], qbit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= DIV_CNT_W'(DIV_STEPS - 1);
         end else if (busy_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= num;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign status.done     = done_ff;
   assign status.quotient = quo_ff[VAL_W-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/area_average_downscaler_top.sv
`default_nettype none

// channel   direction  handshake              payload
// req_      in         req_tvalid/req_tready  tdata: sample_a, sample_b, sample_c
// rsp_      out        rsp_tvalid/rsp_tready  tdata: value, col, row; tuser; tlast
// csr_      in         csr_we                 csr_index, csr_wdata
//
// an item is accepted in idle, then the column memory is read-modify-written; an item that
// closes a window also waits for the 26-bit by 18-bit divider (2 bits a cycle)
// each result then goes out while rsp_tready is high; at most 4 per item
// after reset and after every write to a known register the column memory is
// cleared, one entry a cycle, through all MAX_DST_WIDTH entries; no item is taken meanwhile
// reset is synchronous, active high; a stalled result holds the block in emit

module area_average_downscaler_top #(
   parameter int MAX_DST_WIDTH = 4096,
   parameter int MAX_SRC_DIM   = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [23:0]                    req_tdata,   // sample_a, sample_b, sample_c
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [31:0]                    rsp_tdata,   // out_value, out_col, out_row
   output logic [1:0]                     rsp_tuser,   // empty_window, frame_end
   output logic                           rsp_tlast,   // run_last
   input  logic                           csr_we,
   input  logic [asd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [asd_pkg::RATIO_W-1:0]    csr_wdata
);
   import asd_pkg::*;

   localparam int ADDR_W = $clog2(MAX_DST_WIDTH);
   localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MAX_DST_WIDTH - 1);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_RMW   = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] cnt;
   } entry_type;

   // empty-window results still owed by the current item
   typedef struct packed {
      logic             cp_active;
      logic [DIM_W-1:0] cp_col;
      logic [DIM_W-1:0] cp_row;
      logic             rp_active;
      logic [DIM_W-1:0] rp_row;
      logic [DIM_W-1:0] rp_col;
      logic [N_W-1:0]   n;
   } gen_type;

   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v, input int maxv);
      if (v == '0) return DIM_W'(1);
      if (32'(v) > maxv) return DIM_W'(maxv);
      return v;
   endfunction

   function automatic logic [DIM_W-1:0] win_end(input logic [ACC_W-1:0] acc,
                                                input logic [DIM_W-1:0] dim);
      logic [E_W-1:0] e;
      e = acc[ACC_W-1:FRAC_W];
      if (e > E_W'(dim)) return dim - 1'b1;
      return DIM_W'(e - 1'b1);
   endfunction

   function automatic logic gen_cand(input gen_type g, input logic [DIM_W-1:0] dw,
                                     input logic [DIM_W-1:0] dh);
      return (g.n < N_W'(RESULT_BUDGET)) &&
             ((g.cp_active && g.cp_col < dw) || (g.rp_active && g.rp_row < dh));
   endfunction

   function automatic gen_type gen_next(input gen_type g, input logic [DIM_W-1:0] dw);
      gen_type g2;
      g2 = g;
      if (g.cp_active && g.cp_col < dw) begin
         g2.cp_col = g.cp_col + 1'b1;
      end else if (DIM_W'(g.rp_col + 1'b1) == dw) begin
         g2.rp_col = '0;
         g2.rp_row = g.rp_row + 1'b1;
      end else begin
         g2.rp_col = g.rp_col + 1'b1;
      end
      g2.n = g.n + 1'b1;
      return g2;
   endfunction

   // configuration
   logic               color_mode_ff, color_mode_in;
   logic [DIM_W-1:0]   src_width_ff, src_width_in;
   logic [DIM_W-1:0]   src_height_ff, src_height_in;
   logic [DIM_W-1:0]   dst_width_ff, dst_width_in;
   logic [DIM_W-1:0]   dst_height_ff, dst_height_in;
   logic [RATIO_W-1:0] step_ratio_ff, step_ratio_in;
   logic               cfg_hit;

   logic [DIM_W-1:0]   sw_eff, sh_eff, dw_eff, dh_eff;
   logic [RATIO_W-1:0] ratio_eff;
   logic [ACC_W-1:0]   acc_init;

   // control
   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic [DIM_W-1:0]   src_col_ff, src_col_in;
   logic [DIM_W-1:0]   src_row_ff, src_row_in;
   logic [DIM_W-1:0]   dst_col_ff, dst_col_in;
   logic [DIM_W-1:0]   dst_row_ff, dst_row_in;
   logic [ACC_W-1:0]   acc_col_ff, acc_col_in;
   logic [ACC_W-1:0]   acc_row_ff, acc_row_in;
   logic [DIM_W-1:0]   col_end_ff, col_end_in;
   logic [DIM_W-1:0]   row_end_ff, row_end_in;
   gen_type            gen_ff, gen_in, gen_nx;
   logic               main_pending_ff, main_pending_in;
   logic               frame_done_ff, frame_done_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // payload
   logic [PIX_W-1:0]    v_ff, v_in;
   logic [WEIGHT_W-1:0] w_ff, w_in;
   logic [VAL_W-1:0]    main_value_ff, main_value_in;
   logic [COL_W-1:0]    main_col_ff, main_col_in;
   logic [COL_W-1:0]    main_row_ff, main_row_in;
   logic                main_empty_ff, main_empty_in;
   logic [VAL_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [COL_W-1:0]    rsp_col_ff, rsp_col_in;
   logic [COL_W-1:0]    rsp_row_ff, rsp_row_in;
   logic                rsp_empty_ff, rsp_empty_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_frame_end_ff, rsp_frame_end_in;

   // column memory
   entry_type           col_mem [MAX_DST_WIDTH];
   entry_type           rd_entry_ff;
   logic                mem_we, mem_re;
   logic [ADDR_W-1:0]   mem_waddr;
   entry_type           mem_wdata;

   // read-modify-write terms
   logic                row_act, col_act, act, hit, col_adv, xe, ye, bottom;
   logic [SUM_W-1:0]    sum_new;
   logic [CNT_W-1:0]    cnt_new;
   logic [DIM_W-1:0]    dcol_adv, drow_adv;
   logic                div_start;
   div_status_type      div_status;
   logic                cols_cand, last_flag;
   logic [COL_W-1:0]    pick_col, pick_row;

   assign sw_eff    = eff_dim(src_width_ff, MAX_SRC_DIM);
   assign sh_eff    = eff_dim(src_height_ff, MAX_SRC_DIM);
   assign dw_eff    = eff_dim(dst_width_ff, MAX_DST_WIDTH);
   assign dh_eff    = eff_dim(dst_height_ff, MAX_SRC_DIM);
   assign ratio_eff = (step_ratio_ff < ONE_Q16) ? ONE_Q16 : step_ratio_ff;
   assign acc_init  = ACC_W'(ratio_eff) + ACC_W'(HALF_Q16);

   assign row_act  = dst_row_ff < dh_eff;
   assign col_act  = dst_col_ff < dw_eff;
   assign act      = row_act && col_act;
   assign sum_new  = rd_entry_ff.sum + SUM_W'(v_ff);
   assign cnt_new  = rd_entry_ff.cnt + CNT_W'(w_ff);
   assign hit      = act && src_row_ff == row_end_ff && src_col_ff == col_end_ff;
   assign col_adv  = col_act && src_col_ff == col_end_ff;
   assign dcol_adv = col_adv ? dst_col_ff + 1'b1 : dst_col_ff;
   assign xe       = src_col_ff >= sw_eff - 1'b1;
   assign ye       = src_row_ff >= sh_eff - 1'b1;
   assign bottom   = row_act && src_row_ff == row_end_ff;
   assign drow_adv = bottom ? dst_row_ff + 1'b1 : dst_row_ff;

   assign gen_nx    = gen_next(gen_ff, dw_eff);
   assign cols_cand = gen_ff.cp_active && gen_ff.cp_col < dw_eff;
   assign pick_col  = cols_cand ? gen_ff.cp_col[COL_W-1:0] : gen_ff.rp_col[COL_W-1:0];
   assign pick_row  = cols_cand ? gen_ff.cp_row[COL_W-1:0] : gen_ff.rp_row[COL_W-1:0];

   assign mem_re = req_tvalid && req_tready;

   asd_divider u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (sum_new),
      .den    (cnt_new),
      .status (div_status)
   );

   always_comb begin
      state_in        = state_ff;
      clr_addr_in     = clr_addr_ff;
      src_col_in      = src_col_ff;
      src_row_in      = src_row_ff;
      dst_col_in      = dst_col_ff;
      dst_row_in      = dst_row_ff;
      acc_col_in      = acc_col_ff;
      acc_row_in      = acc_row_ff;
      col_end_in      = win_end(acc_col_ff, sw_eff);
      row_end_in      = win_end(acc_row_ff, sh_eff);
      gen_in          = gen_ff;
      main_pending_in = main_pending_ff;
      frame_done_in   = frame_done_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      v_in            = v_ff;
      w_in            = w_ff;
      main_value_in   = main_value_ff;
      main_col_in     = main_col_ff;
      main_row_in     = main_row_ff;
      main_empty_in   = main_empty_ff;
      rsp_value_in    = rsp_value_ff;
      rsp_col_in      = rsp_col_ff;
      rsp_row_in      = rsp_row_ff;
      rsp_empty_in    = rsp_empty_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_frame_end_in = rsp_frame_end_ff;
      color_mode_in   = color_mode_ff;
      src_width_in    = src_width_ff;
      src_height_in   = src_height_ff;
      dst_width_in    = dst_width_ff;
      dst_height_in   = dst_height_ff;
      step_ratio_in   = step_ratio_ff;
      cfg_hit         = 1'b0;
      mem_we          = 1'b0;
      mem_waddr       = ADDR_W'(dst_col_ff);
      mem_wdata       = '0;
      div_start       = 1'b0;
      last_flag       = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            mem_we          = 1'b1;
            mem_waddr       = clr_addr_ff;
            src_col_in      = '0;
            src_row_in      = '0;
            dst_col_in      = '0;
            dst_row_in      = '0;
            acc_col_in      = acc_init;
            acc_row_in      = acc_init;
            gen_in          = '0;
            main_pending_in = 1'b0;
            clr_addr_in     = clr_addr_ff + 1'b1;
            if (clr_addr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               if (color_mode_ff) begin
                  v_in = PIX_W'(req_tdata[7:0]) + PIX_W'(req_tdata[15:8])
                       + PIX_W'(req_tdata[23:16]);
                  w_in = WEIGHT_W'(3);
               end else begin
                  v_in = PIX_W'(req_tdata[7:0]);
                  w_in = WEIGHT_W'(1);
               end
               state_in = ST_RMW;
            end
         end
         ST_RMW: begin
            mem_we          = act;
            mem_wdata       = hit ? '0 : {sum_new, cnt_new};
            main_col_in     = dst_col_ff[COL_W-1:0];
            main_row_in     = dst_row_ff[COL_W-1:0];
            main_empty_in   = cnt_new == '0;
            main_value_in   = '0;
            main_pending_in = hit;
            div_start       = hit && cnt_new != '0;
            gen_in          = '0;
            gen_in.n        = hit ? N_W'(1) : '0;
            frame_done_in   = 1'b0;
            if (col_adv) begin
               acc_col_in = acc_col_ff + ACC_W'(ratio_eff);
            end
            if (xe) begin
               // end of source row: owed empty columns if a window row closes, then maybe owed empty rows
               gen_in.cp_active = bottom;
               gen_in.cp_col    = dcol_adv;
               gen_in.cp_row    = dst_row_ff;
               dst_col_in       = '0;
               acc_col_in       = acc_init;
               src_col_in       = '0;
               if (bottom) begin
                  acc_row_in = acc_row_ff + ACC_W'(ratio_eff);
               end
               if (ye) begin
                  gen_in.rp_active = 1'b1;
                  gen_in.rp_row    = drow_adv;
                  gen_in.rp_col    = '0;
                  dst_row_in       = '0;
                  acc_row_in       = acc_init;
                  src_row_in       = '0;
                  frame_done_in    = 1'b1;
               end else begin
                  src_row_in = src_row_ff + 1'b1;
                  dst_row_in = drow_adv;
               end
            end else begin
               src_col_in = src_col_ff + 1'b1;
               dst_col_in = dcol_adv;
            end
            if (hit && cnt_new != '0) begin
               state_in = ST_DIV;
            end else if (hit || gen_cand(gen_in, dw_eff, dh_eff)) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               main_value_in = div_status.quotient;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               if (main_pending_ff) begin
                  last_flag       = !gen_cand(gen_ff, dw_eff, dh_eff);
                  rsp_value_in    = main_value_ff;
                  rsp_col_in      = main_col_ff;
                  rsp_row_in      = main_row_ff;
                  rsp_empty_in    = main_empty_ff;
                  main_pending_in = 1'b0;
               end else begin
                  last_flag    = !gen_cand(gen_nx, dw_eff, dh_eff);
                  rsp_value_in = '0;
                  rsp_col_in   = pick_col;
                  rsp_row_in   = pick_row;
                  rsp_empty_in = 1'b1;
                  gen_in       = gen_nx;
               end
               rsp_last_in      = last_flag;
               rsp_frame_end_in = last_flag && frame_done_ff;
               if (last_flag) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in    = ST_CLEAR;
            clr_addr_in = '0;
         end
      endcase

      if (csr_we) begin
         cfg_hit = 1'b1;
         case (csr_index)
            CSR_COLOR_MODE: color_mode_in = csr_wdata[0];
            CSR_SRC_WIDTH:  src_width_in  = csr_wdata[DIM_W-1:0];
            CSR_SRC_HEIGHT: src_height_in = csr_wdata[DIM_W-1:0];
            CSR_DST_WIDTH:  dst_width_in  = csr_wdata[DIM_W-1:0];
            CSR_DST_HEIGHT: dst_height_in = csr_wdata[DIM_W-1:0];
            CSR_STEP_RATIO: step_ratio_in = csr_wdata;
            default:        cfg_hit       = 1'b0;
         endcase
         // a known register write restarts the frame
         if (cfg_hit) begin
            state_in    = ST_CLEAR;
            clr_addr_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_addr_ff     <= '0;
         src_col_ff      <= '0;
         src_row_ff      <= '0;
         dst_col_ff      <= '0;
         dst_row_ff      <= '0;
         acc_col_ff      <= '0;
         acc_row_ff      <= '0;
         col_end_ff      <= '0;
         row_end_ff      <= '0;
         gen_ff          <= '0;
         main_pending_ff <= 1'b0;
         frame_done_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         color_mode_ff   <= 1'b0;
         src_width_ff    <= DIM_W'(640);
         src_height_ff   <= DIM_W'(480);
         dst_width_ff    <= DIM_W'(640);
         dst_height_ff   <= DIM_W'(480);
         step_ratio_ff   <= ONE_Q16;
      end else begin
         state_ff        <= state_in;
         clr_addr_ff     <= clr_addr_in;
         src_col_ff      <= src_col_in;
         src_row_ff      <= src_row_in;
         dst_col_ff      <= dst_col_in;
         dst_row_ff      <= dst_row_in;
         acc_col_ff      <= acc_col_in;
         acc_row_ff      <= acc_row_in;
         col_end_ff      <= col_end_in;
         row_end_ff      <= row_end_in;
         gen_ff          <= gen_in;
         main_pending_ff <= main_pending_in;
         frame_done_ff   <= frame_done_in;
         rsp_valid_ff    <= rsp_valid_in;
         color_mode_ff   <= color_mode_in;
         src_width_ff    <= src_width_in;
         src_height_ff   <= src_height_in;
         dst_width_ff    <= dst_width_in;
         dst_height_ff   <= dst_height_in;
         step_ratio_ff   <= step_ratio_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff             <= v_in;
      w_ff             <= w_in;
      main_value_ff    <= main_value_in;
      main_col_ff      <= main_col_in;
      main_row_ff      <= main_row_in;
      main_empty_ff    <= main_empty_in;
      rsp_value_ff     <= rsp_value_in;
      rsp_col_ff       <= rsp_col_in;
      rsp_row_ff       <= rsp_row_in;
      rsp_empty_ff     <= rsp_empty_in;
      rsp_last_ff      <= rsp_last_in;
      rsp_frame_end_ff <= rsp_frame_end_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         col_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_entry_ff <= col_mem[ADDR_W'(dst_col_ff)];
      end
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_row_ff, rsp_col_ff, rsp_value_ff};
   assign rsp_tuser  = {rsp_frame_end_ff, rsp_empty_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire
